// ===== rtl/wmax_pkg.sv =====
// Shared constants, types and helpers for the 3x3 window maximum filter.
package wmax_pkg;

   localparam int MAX_WIDTH       = 1024;
   localparam int SAMPLE_BITS     = 16;
   localparam int COL_BITS        = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS      = COL_BITS + 1;
   localparam int ROW_BITS        = 16;
   localparam int LINE_BITS       = 2 * SAMPLE_BITS;
   localparam int WIN_TAPS        = 6;
   localparam int OUT_FIFO_DEPTH  = 4;
   localparam int OUT_PTR_BITS    = $clog2(OUT_FIFO_DEPTH);
   localparam int OUT_CNT_BITS    = OUT_PTR_BITS + 1;
   localparam int REQ_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS  = SAMPLE_BITS + ROW_BITS + COL_BITS;
   localparam int RSP_DATA_BITS   = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = WIDTH_BITS'(3);
   localparam logic [WIDTH_BITS-1:0] MIN_WIDTH       = WIDTH_BITS'(3);
   localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_W     = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [ROW_BITS-1:0]   ROW_TOP         = {ROW_BITS{1'b1}};
   localparam logic [ROW_BITS-1:0]   ROW_FIRST_FULL  = ROW_BITS'(2);
   localparam logic [COL_BITS-1:0]   COL_FIRST_FULL  = COL_BITS'(2);

   // one item on its way from the counters to the window stage
   typedef struct packed {
      logic                   emit;
      logic [COL_BITS-1:0]    col;
      logic [ROW_BITS-1:0]    block_row;
      logic [COL_BITS-1:0]    block_col;
      logic                   row_last;
      logic [SAMPLE_BITS-1:0] reading;
   } stage_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] block_max;
      logic [ROW_BITS-1:0]    block_row;
      logic [COL_BITS-1:0]    block_col;
      logic                   row_last;
   } result_type;

   function automatic logic [SAMPLE_BITS-1:0] max2(input logic [SAMPLE_BITS-1:0] a,
                                                   input logic [SAMPLE_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [ROW_BITS-1:0] next_row(input logic [ROW_BITS-1:0] r);
      return (r == ROW_TOP) ? ROW_TOP : r + ROW_BITS'(1);
   endfunction

endpackage

// ===== rtl/wmax_line_ram.sv =====
// Simple dual-port line store: one write port, one read port, registered read data.
module wmax_line_ram #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wmax_ctrl.sv =====
// Row width register, column and row counters, and the read issue for the line store.
module wmax_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [wmax_pkg::WIDTH_BITS-1:0] csr_wdata,
   input  logic                            accept,
   input  logic [wmax_pkg::SAMPLE_BITS-1:0] reading,
   input  logic                            frame_start,
   output logic                            rd_en,
   output logic [wmax_pkg::COL_BITS-1:0]   rd_addr,
   output logic                            s1_valid,
   output wmax_pkg::stage_type             s1_item
);
   import wmax_pkg::*;

   logic [WIDTH_BITS-1:0] row_width_ff;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic                  s1_valid_ff;
   stage_type             s1_item_ff, s1_item_in;

   logic [WIDTH_BITS-1:0] width_eff;
   logic [COL_BITS-1:0]   cur_col;
   logic [ROW_BITS-1:0]   cur_row;
   logic [WIDTH_BITS-1:0] col_next;

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = WIDTH_BITS'(1);
      end else if (row_width_ff > MAX_WIDTH_W) begin
         width_eff = MAX_WIDTH_W;
      end else begin
         width_eff = row_width_ff;
      end
   end

   always_comb begin
      // frame start wins; a column beyond a shrunk width opens a new row
      if (frame_start) begin
         cur_col = '0;
         cur_row = '0;
      end else if ({1'b0, col_ff} >= width_eff) begin
         cur_col = '0;
         cur_row = next_row(row_ff);
      end else begin
         cur_col = col_ff;
         cur_row = row_ff;
      end
      col_next = {1'b0, cur_col} + WIDTH_BITS'(1);
      if (col_next >= width_eff) begin
         col_in = '0;
         row_in = next_row(cur_row);
      end else begin
         col_in = col_next[COL_BITS-1:0];
         row_in = cur_row;
      end
   end

   always_comb begin
      s1_item_in.emit      = (width_eff >= MIN_WIDTH) && (cur_row >= ROW_FIRST_FULL) &&
                             (cur_col >= COL_FIRST_FULL);
      s1_item_in.col       = cur_col;
      s1_item_in.block_row = cur_row - ROW_FIRST_FULL;
      s1_item_in.block_col = cur_col - COL_FIRST_FULL;
      s1_item_in.row_last  = ({1'b0, cur_col} == (width_eff - WIDTH_BITS'(1)));
      s1_item_in.reading   = reading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            row_width_ff <= csr_wdata;
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
   end

   assign rd_en    = accept;
   assign rd_addr  = cur_col;
   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

endmodule

// ===== rtl/wmax_window.sv =====
// Window stage: forwards line data, takes the 3x3 maximum and writes the rows back.
module wmax_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [wmax_pkg::COL_BITS-1:0]    rd_addr,
   input  logic [wmax_pkg::LINE_BITS-1:0]   rd_data,
   input  logic                             s1_valid,
   input  wmax_pkg::stage_type              s1_item,
   output logic                             wr_en,
   output logic [wmax_pkg::COL_BITS-1:0]    wr_addr,
   output logic [wmax_pkg::LINE_BITS-1:0]   wr_data,
   output logic                             push,
   output wmax_pkg::result_type             push_data
);
   import wmax_pkg::*;

   logic                   fwd_hit_ff;
   logic [LINE_BITS-1:0]   fwd_data_ff;
   logic [SAMPLE_BITS-1:0] win_ff [WIN_TAPS];

   logic [LINE_BITS-1:0]   line;
   logic [SAMPLE_BITS-1:0] up, mid, cur;
   logic [SAMPLE_BITS-1:0] m01, m23, m45, m67, m0123, m4567, m_all;

   // a write to the column being read this cycle lands after the read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= rd_en && s1_valid && (rd_addr == s1_item.col);
      end
      fwd_data_ff <= wr_data;
   end

   always_comb begin
      line = fwd_hit_ff ? fwd_data_ff : rd_data;
      up   = line[LINE_BITS-1:SAMPLE_BITS];
      mid  = line[SAMPLE_BITS-1:0];
      cur  = s1_item.reading;
   end

   always_comb begin
      m01   = max2(win_ff[0], win_ff[1]);
      m23   = max2(win_ff[2], win_ff[3]);
      m45   = max2(win_ff[4], win_ff[5]);
      m67   = max2(up, mid);
      m0123 = max2(m01, m23);
      m4567 = max2(m45, m67);
      m_all = max2(max2(m0123, m4567), cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up;
         win_ff[4] <= mid;
         win_ff[5] <= cur;
      end
   end

   assign wr_en   = s1_valid;
   assign wr_addr = s1_item.col;
   assign wr_data = {mid, cur};

   assign push                = s1_valid && s1_item.emit;
   assign push_data.block_max = m_all;
   assign push_data.block_row = s1_item.block_row;
   assign push_data.block_col = s1_item.block_col;
   assign push_data.row_last  = s1_item.row_last;

endmodule

// ===== rtl/wmax_out_fifo.sv =====
// Result buffer: small register queue that decouples the window stage from rsp stalls.
module wmax_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wmax_pkg::result_type push_data,
   input  logic                 pending,
   output logic                 room,
   output logic                 pop_valid,
   output wmax_pkg::result_type pop_data,
   input  logic                 pop_ready
);
   import wmax_pkg::*;

   result_type              entry_ff [OUT_FIFO_DEPTH];
   logic [OUT_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_BITS-1:0] occ_ff, occ_in;
   logic                    pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (occ_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // keep space for the item in the window stage and one more behind it
   assign room = ((occ_ff + OUT_CNT_BITS'(pending)) <= OUT_CNT_BITS'(OUT_FIFO_DEPTH - 2));

   always_comb begin
      occ_in = occ_ff;
      if (push && !pop) begin
         occ_in = occ_ff + OUT_CNT_BITS'(1);
      end else if (pop && !push) begin
         occ_in = occ_ff - OUT_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_BITS'(1);
         end
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OUT_CNT_BITS'(OUT_FIFO_DEPTH))
      else $error("result buffer occupancy out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (occ_ff == OUT_CNT_BITS'(OUT_FIFO_DEPTH))))
      else $error("result pushed into a full buffer");

   a_room_headroom: assert property (@(posedge clock) disable iff (reset)
      (room && pending) |-> (occ_ff <= OUT_CNT_BITS'(OUT_FIFO_DEPTH - 3)))
      else $error("input admitted without headroom in the result buffer");
`endif

endmodule

// ===== rtl/window_max_3x3_unit.sv =====
// Streaming 3x3 maximum filter: top level.
// Throughput: one reading per cycle through the line store read, window stage and result
// buffer; req_tready drops while buffered results plus the window stage item exceed two.
// Reset clears the counters, the window and the four-entry result buffer and sets row
// width 3; the line stores are not cleared.
module window_max_3x3_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [wmax_pkg::WIDTH_BITS-1:0]     csr_wdata,     // row_width
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wmax_pkg::REQ_DATA_BITS-1:0]  req_tdata,     // [15:0] reading
   input  logic                                req_tuser,     // frame_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] block_max, [31:16] block_row, [41:32] block_col, rest zero
   output logic [wmax_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast      // row_last
);
   import wmax_pkg::*;

   logic                   accept;
   logic                   rd_en, wr_en;
   logic [COL_BITS-1:0]    rd_addr, wr_addr;
   logic [LINE_BITS-1:0]   rd_data, wr_data;
   logic                   s1_valid;
   stage_type              s1_item;
   logic                   push, room;
   result_type             push_data, pop_data;

   assign req_tready = room;
   assign accept     = req_tvalid && req_tready;

   wmax_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .reading     (req_tdata[SAMPLE_BITS-1:0]),
      .frame_start (req_tuser),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .s1_valid    (s1_valid),
      .s1_item     (s1_item)
   );

   wmax_line_ram #(
      .ADDR_BITS (COL_BITS),
      .DATA_BITS (LINE_BITS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wmax_window u_window (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_data (push_data)
   );

   wmax_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pending   (s1_valid),
      .room      (room),
      .pop_valid (rsp_tvalid),
      .pop_data  (pop_data),
      .pop_ready (rsp_tready)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}},
                       pop_data.block_col, pop_data.block_row, pop_data.block_max};
   assign rsp_tlast = pop_data.row_last;

endmodule

// ===== dv/tb_window_max_3x3_unit.sv =====
// Self-checking testbench for the streaming 3x3 window maximum filter.
module tb_window_max_3x3_unit;
   import wmax_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [WIDTH_BITS-1:0]    csr_wdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   window_max_3x3_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Filter shadow: line stores, window, counters and the queue of due block maxima.
   class block_max_scoreboard;
      logic [SAMPLE_BITS-1:0] upper_line [MAX_WIDTH];
      logic [SAMPLE_BITS-1:0] middle_line [MAX_WIDTH];
      bit                     upper_written [MAX_WIDTH];
      bit                     middle_written [MAX_WIDTH];
      logic [SAMPLE_BITS-1:0] win [WIN_TAPS];
      int unsigned            col;
      int unsigned            row;
      logic [WIDTH_BITS-1:0]  width;
      result_type             due_q [$];
      int unsigned            errors;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i]     = '0;
            middle_line[i]    = '0;
            upper_written[i]  = 1'b0;
            middle_written[i] = 1'b0;
         end
         foreach (win[k]) win[k] = '0;
         col    = 0;
         row    = 0;
         width  = ROW_WIDTH_RESET;
         errors = 0;
      endfunction

      function void set_width(logic [WIDTH_BITS-1:0] w);
         width = w;
      endfunction

      function int unsigned eff_width();
         if (width == '0) return 1;
         if (width > MAX_WIDTH_W) return MAX_WIDTH;
         return 32'(width);
      endfunction

      // leading columns whose upper store entry holds a reading (not a never-written value)
      function int unsigned written_span();
         int unsigned n;
         n = 0;
         while (n < MAX_WIDTH && upper_written[COL_BITS'(n)]) n++;
         return n;
      endfunction

      function int unsigned bump_row(int unsigned r);
         return (r >= ROW_TOP) ? ROW_TOP : r + 1;
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction

      function void note_reading(logic [SAMPLE_BITS-1:0] rd, bit frame_start);
         int unsigned            w;
         int unsigned            c;
         logic [COL_BITS-1:0]    ci;
         logic [SAMPLE_BITS-1:0] up;
         logic [SAMPLE_BITS-1:0] mid;
         logic [SAMPLE_BITS-1:0] m;
         result_type             res;
         w = eff_width();
         if (frame_start) begin
            col = 0;
            row = 0;
         end else if (col >= w) begin
            // width shrunk under the current column: this reading opens a new row
            col = 0;
            row = bump_row(row);
         end
         c   = col;
         ci  = COL_BITS'(c);
         up  = upper_line[ci];
         mid = middle_line[ci];
         if (w >= 3 && row >= 2 && c >= 2) begin
            m = rd;
            if (up > m) m = up;
            if (mid > m) m = mid;
            foreach (win[k]) if (win[k] > m) m = win[k];
            res.block_max = m;
            res.block_row = ROW_BITS'(row - 2);
            res.block_col = COL_BITS'(c - 2);
            res.row_last  = (c == w - 1);
            due_q.push_back(res);
         end
         upper_line[ci]     = mid;
         middle_line[ci]    = rd;
         upper_written[ci]  = middle_written[ci];
         middle_written[ci] = 1'b1;
         win[0] = win[3];
         win[1] = win[4];
         win[2] = win[5];
         win[3] = up;
         win[4] = mid;
         win[5] = rd;
         if (c + 1 >= w) begin
            col = 0;
            row = bump_row(row);
         end else begin
            col = c + 1;
         end
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [RSP_DATA_BITS-1:0] data, logic last);
         result_type want;
         if (due_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual tdata %0h tlast %b",
                     $time, data, last);
            return;
         end
         want = due_q.pop_front();
         compare_field("block_max", 64'(want.block_max), 64'(data[SAMPLE_BITS-1:0]));
         compare_field("block_row", 64'(want.block_row),
                       64'(data[SAMPLE_BITS+ROW_BITS-1:SAMPLE_BITS]));
         compare_field("block_col", 64'(want.block_col),
                       64'(data[RSP_FIELD_BITS-1:SAMPLE_BITS+ROW_BITS]));
         compare_field("row_last", 64'(want.row_last), 64'(last));
         compare_field("tdata pad", 64'(0), 64'(data[RSP_DATA_BITS-1:RSP_FIELD_BITS]));
      endfunction
   endclass

   block_max_scoreboard sb;
   int unsigned         burst_left;
   int unsigned         hold_ask;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #36_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // result monitor
   always @(posedge clock) begin
      if (sb != null && !reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast);
   end

   // receiver: one of four stall patterns, redrawn at random, plus long hold-offs on request
   initial begin
      int unsigned left;
      int unsigned mode;
      int unsigned holds;
      left  = 0;
      mode  = 0;
      holds = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 300);
         end
         left--;
         if (holds < hold_ask) begin
            // long hold-off so the result buffer fills and req_tready drops
            holds++;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ((left % 16) >= 4);
            endcase
         end
      end
   end

   // one reading per call; returns once taken, or after any idle gap at a burst's end
   task automatic send_item(input logic [SAMPLE_BITS-1:0] rd, input bit frame_start);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(rd);
      req_tuser  <= frame_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_reading(rd, frame_start);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [SAMPLE_BITS-1:0] rand_reading();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic send_run(input int unsigned n, input bit start, input bit noisy);
      bit fs;
      for (int unsigned i = 0; i < n; i++) begin
         fs = (i == 0) ? start : (noisy && $urandom_range(0, 99) < 2);
         send_item(rand_reading(), fs);
      end
   endtask

   // sender pause until every due result is out and the pipeline is empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_width(input int unsigned w);
      csr_we    <= 1'b1;
      csr_wdata <= WIDTH_BITS'(w);
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_width(WIDTH_BITS'(w));
      @(posedge clock);
   endtask

   function automatic int unsigned pick_frame_width();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return $urandom_range(0, 2);
      if (r < 85) return $urandom_range(3, 10);
      if (r < 97) return $urandom_range(11, 64);
      return $urandom_range(65, 400);
   endfunction

   initial begin
      logic [SAMPLE_BITS-1:0] grid [12];
      int unsigned            rand_items;
      int unsigned            cur;
      int unsigned            span;
      int unsigned            new_w;
      int unsigned            e;
      int unsigned            n;
      int unsigned            guard;
      bit                     start;

      sb         = new();
      burst_left = 0;
      hold_ask   = 0;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset width of 3, field extremes, then narrow widths
      grid = '{16'h0000, 16'hFFFF, 16'h0000,
               16'hAAAA, 16'h5555, 16'h0001,
               16'h8000, 16'h0000, 16'h7FFF,
               16'h0000, 16'h0000, 16'h0000};
      foreach (grid[i]) send_item(grid[i], i == 0);
      wait_idle();
      write_width(2);
      send_run(4, 1'b0, 1'b0);
      wait_idle();
      write_width(0);
      send_run(3, 1'b1, 1'b0);
      wait_idle();
      write_width(1);
      send_run(3, 1'b0, 1'b0);

      // width shrunk while the column counter sits beyond the new width
      wait_idle();
      write_width(6);
      send_run(22, 1'b1, 1'b0);
      wait_idle();
      write_width(3);
      send_run(6, 1'b0, 1'b0);

      // a width above the store size saturates to the widest row
      wait_idle();
      write_width(2047);
      send_run(6, 1'b1, 1'b0);

      // receiver holds off while a width 3 frame keeps arriving
      wait_idle();
      write_width(3);
      hold_ask = 1;
      send_run(60, 1'b1, 1'b0);

      // random frames, with mid-frame width changes and stray frame starts
      rand_items = 0;
      while (rand_items < 1150) begin
         cur = sb.eff_width();
         wait_idle();
         if ($urandom_range(0, 3) == 0) begin
            // carry on the current frame under a new width; a raise only over
            // columns already held in both line stores
            span = sb.written_span();
            if (span > cur && $urandom_range(0, 1) == 1)
               new_w = $urandom_range(cur + 1, (span < cur + 16) ? span : cur + 16);
            else
               new_w = $urandom_range(0, cur);
            write_width(new_w);
            n     = $urandom_range(1, 3 * sb.eff_width());
            start = 1'b0;
         end else begin
            write_width(pick_frame_width());
            e = sb.eff_width();
            n = e * $urandom_range(3, (e > 64) ? 3 : 6);
            if ($urandom_range(0, 2) == 0) n += $urandom_range(0, e - 1);
            start = 1'b1;
         end
         send_run(n, start, 1'b1);
         rand_items += n;
      end

      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors += sb.pending();
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
      end
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
